// ===== hdl/sma_pkg.sv =====
// Shared types, constants and helpers for the square matrix arithmetic core.
package sma_pkg;

	localparam int MAX_DIM = 8;
	localparam int ELEM_W  = 16;
	localparam int IN_W    = 16;
	localparam int RES_W   = 35;
	localparam int POS_W   = 3;
	localparam int DIM_W   = 4;
	localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W  = 2 * ELEM_W;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_EQ  = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_OPERATION = 1'b0,
		REG_DIM       = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'd0,
		BK_WAIT  = 2'd1,
		BK_ISSUE = 2'd2
	} bk_state_t;

	// One queued request: either an element load or a compute.
	typedef struct packed {
		logic                     is_comp;
		logic                     is_b;
		logic [ADDR_W-1:0]        addr;
		logic signed [ELEM_W-1:0] elem;
	} q_item_t;

	typedef struct packed {
		op_t              op;
		logic [DIM_W-1:0] dim;
	} cfg_t;

	// Tag that travels with each RAM read through the back end.
	typedef struct packed {
		op_t              op;
		logic             first;
		logic             fin;
		logic             last_item;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
	} tag_t;

	function automatic logic signed [ELEM_W-1:0] to_elem(input logic signed [IN_W-1:0] v);
		logic signed [31:0] ext;
		ext = 32'(v);
		return ext[ELEM_W-1:0];
	endfunction

	// Highest index in use: dim 0 acts as 1, above MAX_DIM acts as MAX_DIM.
	function automatic logic [IDX_W-1:0] eff_nm1(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] dm1;
		dm1 = d - 1'b1;
		if (d == '0)
			return '0;
		else if (d > DIM_W'(MAX_DIM))
			return IDX_W'(MAX_DIM - 1);
		else
			return dm1[IDX_W-1:0];
	endfunction

endpackage

// ===== hdl/sma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/sma_front.sv =====
// Front end: accepts input requests, drops ignored ones, builds queue entries.
module sma_front import sma_pkg::*; (
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [POS_W-1:0]       row,
	input  logic [POS_W-1:0]       col,
	input  logic signed [IN_W-1:0] value,
	input  logic                   q_full,
	output logic                   push,
	output q_item_t                item
);

	logic in_range;
	logic keep;

	assign in_ready = !q_full;
	assign in_range = ({1'b0, row} < (POS_W + 1)'(MAX_DIM)) &&
	                  ({1'b0, col} < (POS_W + 1)'(MAX_DIM));

	always_comb begin
		keep         = 1'b0;
		item.is_comp = 1'b0;
		item.is_b    = 1'b0;
		item.addr    = ADDR_W'(row * MAX_DIM + col);
		item.elem    = to_elem(value);
		unique case (cmd_t'(command))
			CMD_LOAD_A: begin
				keep = in_range;
			end
			CMD_LOAD_B: begin
				keep      = in_range;
				item.is_b = 1'b1;
			end
			CMD_COMPUTE: begin
				keep         = 1'b1;
				item.is_comp = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = in_valid && in_ready && keep;

endmodule

// ===== hdl/sma_queue.sv =====
// Short request queue between the front end and the back end.
module sma_queue import sma_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output q_item_t head_item
);

	q_item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_pop;

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== hdl/sma_back.sv =====
// Back end: element stores, read sequencer, arithmetic pipeline, result register.
module sma_back import sma_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    q_valid,
	input  q_item_t                 q_item,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [POS_W-1:0]        row_res,
	output logic [POS_W-1:0]        col_res,
	output logic signed [RES_W-1:0] value_res,
	output logic                    equal,
	output logic                    last
);

	bk_state_t        state_q, state_d;
	op_t              op_q, op_d;
	logic [IDX_W-1:0] nm1_q, nm1_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

	logic              we_a, we_b, issue;
	logic [ADDR_W-1:0] raddr_a, raddr_b;
	logic [ELEM_W-1:0] rdata_a, rdata_b;
	logic              elem_end, row_end, all_end;
	tag_t              tag_issue;

	logic                     valid_s1, valid_s2;
	tag_t                     tag_s1, tag_s2;
	logic signed [RES_W-1:0]  term_s2;
	logic                     eqb_s2;
	logic signed [ELEM_W-1:0] a_s1, b_s1;
	logic signed [PROD_W-1:0] prod;
	logic signed [63:0]       wide;
	logic signed [RES_W-1:0]  term_d;

	logic signed [RES_W-1:0] acc_q, acc_sum;
	logic                    eq_acc_q, eq_acc_d;

	logic                    out_valid_q;
	logic [POS_W-1:0]        row_res_q, col_res_q;
	logic signed [RES_W-1:0] value_res_q;
	logic                    equal_q, last_q;

	sma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (q_item.addr),
		.wdata (q_item.elem),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	sma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (q_item.addr),
		.wdata (q_item.elem),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// sequencer
	assign row_end  = (j_q == nm1_q);
	assign all_end  = row_end && (i_q == nm1_q);
	assign elem_end = (op_q != OP_MUL) || (k_q == nm1_q);

	always_comb begin
		if (op_q == OP_MUL) begin
			raddr_a = ADDR_W'(i_q * MAX_DIM + k_q);
			raddr_b = ADDR_W'(k_q * MAX_DIM + j_q);
		end else begin
			raddr_a = ADDR_W'(i_q * MAX_DIM + j_q);
			raddr_b = ADDR_W'(i_q * MAX_DIM + j_q);
		end
		tag_issue.op        = op_q;
		tag_issue.i         = i_q;
		tag_issue.j         = j_q;
		tag_issue.last_item = all_end;
		tag_issue.fin       = elem_end && ((op_q != OP_EQ) || all_end);
		case (op_q)
			OP_MUL:  tag_issue.first = (k_q == '0);
			OP_EQ:   tag_issue.first = (i_q == '0) && (j_q == '0);
			default: tag_issue.first = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		nm1_d   = nm1_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		q_pop   = 1'b0;
		we_a    = 1'b0;
		we_b    = 1'b0;
		issue   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.is_comp) begin
						op_d    = cfg.op;
						nm1_d   = eff_nm1(cfg.dim);
						i_d     = '0;
						j_d     = '0;
						k_d     = '0;
						state_d = BK_WAIT;
					end else begin
						we_a = !q_item.is_b;
						we_b = q_item.is_b;
					end
				end
			end
			BK_WAIT: begin
				// start an element only with an empty pipe and a free result slot
				if (!valid_s1 && !valid_s2 && (!out_valid_q || out_ready))
					state_d = BK_ISSUE;
			end
			BK_ISSUE: begin
				issue = 1'b1;
				if (op_q == OP_MUL)
					k_d = elem_end ? '0 : k_q + 1'b1;
				if (elem_end) begin
					if (row_end) begin
						j_d = '0;
						i_d = i_q + 1'b1;
					end else begin
						j_d = j_q + 1'b1;
					end
					if (all_end)
						state_d = BK_IDLE;
					else if (op_q != OP_EQ)
						state_d = BK_WAIT;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			op_q    <= OP_ADD;
			nm1_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			nm1_q   <= nm1_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	// stage 2: element op on RAM data
	assign a_s1 = rdata_a;
	assign b_s1 = rdata_b;
	assign prod = a_s1 * b_s1;

	always_comb begin
		case (tag_s1.op)
			OP_ADD:  wide = 64'(a_s1) + 64'(b_s1);
			OP_SUB:  wide = 64'(a_s1) - 64'(b_s1);
			OP_MUL:  wide = 64'(prod);
			default: wide = '0;
		endcase
		term_d = wide[RES_W-1:0];
	end

	// stage 3: accumulate and load the result register
	assign acc_sum  = (tag_s2.first ? '0 : acc_q) + term_s2;
	assign eq_acc_d = (tag_s2.first ? 1'b1 : eq_acc_q) & eqb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (valid_s2 && tag_s2.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue)
			tag_s1 <= tag_issue;
		if (valid_s1) begin
			tag_s2  <= tag_s1;
			term_s2 <= term_d;
			eqb_s2  <= (a_s1 == b_s1);
		end
		if (valid_s2) begin
			acc_q    <= acc_sum;
			eq_acc_q <= eq_acc_d;
		end
		if (valid_s2 && tag_s2.fin) begin
			last_q <= tag_s2.last_item;
			if (tag_s2.op == OP_EQ) begin
				row_res_q   <= '0;
				col_res_q   <= '0;
				value_res_q <= '0;
				equal_q     <= eq_acc_d;
			end else begin
				row_res_q   <= POS_W'(tag_s2.i);
				col_res_q   <= POS_W'(tag_s2.j);
				value_res_q <= acc_sum;
				equal_q     <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign row_res   = row_res_q;
	assign col_res   = col_res_q;
	assign value_res = value_res_q;
	assign equal     = equal_q;
	assign last      = last_q;

endmodule

// ===== hdl/square_matrix_arithmetic_core.sv =====
// Top level of the square matrix arithmetic core: config registers and wiring.
//
//  channel   dir  handshake             payload
//  -------   ---  ---------             -------
//  in        in   in_valid / in_ready   command, row, col, value
//  out       out  out_valid / out_ready row_res, col_res, value_res, equal, last
//  config    in   APB psel/penable      paddr, pwdata -> prdata (operation, dim)
//
// Loads are stored only while no compute runs; a request is taken every cycle
// while the 4-entry queue has room.
// Add and subtract: one result per element; multiply: n products summed
// per element (one A and one B read per cycle, single read port per store);
// equality: a walk over every element, then one result.
// Reset clears control only; the element stores hold garbage until loaded.
// A stalled output holds the next element back; the queue keeps taking requests until it is full.
module square_matrix_arithmetic_core import sma_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  logic [POS_W-1:0]        row,
	input  logic [POS_W-1:0]        col,
	input  logic signed [IN_W-1:0]  value,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [POS_W-1:0]        row_res,
	output logic [POS_W-1:0]        col_res,
	output logic signed [RES_W-1:0] value_res,
	output logic                    equal,
	output logic                    last,
	// config port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	op_t              op_q;
	logic [DIM_W-1:0] dim_q;
	cfg_t             cfg;
	logic             cfg_we;
	reg_idx_t         reg_idx;

	logic    push, q_full, q_valid, q_pop;
	q_item_t push_item, head_item;

	// config registers; one word each at 4-byte stride
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= OP_ADD;
			dim_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_OPERATION: op_q  <= op_t'(pwdata[1:0]);
				REG_DIM:       dim_q <= pwdata[DIM_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OPERATION: prdata = 32'(op_q);
			REG_DIM:       prdata = 32'(dim_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.op  = op_q;
	assign cfg.dim = dim_q;

	// classify requests
	sma_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.row      (row),
		.col      (col),
		.value    (value),
		.q_full   (q_full),
		.push     (push),
		.item     (push_item)
	);

	// decouple front from the compute engine
	sma_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (head_item)
	);

	// stores, sequencer, arithmetic and result register
	sma_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_res   (row_res),
		.col_res   (col_res),
		.value_res (value_res),
		.equal     (equal),
		.last      (last)
	);

endmodule

// ===== hdl/sma_checker.sv =====
// Port-level checks for the square matrix arithmetic core, bound to the top.
module sma_checker import sma_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [POS_W-1:0]        row_res,
	input logic [POS_W-1:0]        col_res,
	input logic signed [RES_W-1:0] value_res,
	input logic                    equal,
	input logic                    last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(value_res) && $stable(row_res) &&
		$stable(col_res) && $stable(last) && $stable(equal))
		else $error("result changed while stalled");

	a_eq_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && equal |-> last && (row_res == '0) && (col_res == '0) &&
		(value_res == '0))
		else $error("equal flag on a non-final or non-empty item");

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> (row_res == col_res))
		else $error("final item not on the diagonal corner");

endmodule

bind square_matrix_arithmetic_core sma_checker u_sma_checker (.*);

// ===== sim/square_matrix_arithmetic_checker.sv =====
`timescale 1ns / 100ps
// Checker for the matrix core: tracks loads and register writes, predicts and compares results.
module square_matrix_arithmetic_checker import sma_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [1:0]              command,
	input  logic [POS_W-1:0]        row,
	input  logic [POS_W-1:0]        col,
	input  logic signed [IN_W-1:0]  value,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [POS_W-1:0]        row_res,
	input  logic [POS_W-1:0]        col_res,
	input  logic signed [RES_W-1:0] value_res,
	input  logic                    equal,
	input  logic                    last,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	input  logic                    pready,
	output int                      errors,
	output int                      pending,
	output int                      checked
);

	typedef struct {
		logic [POS_W-1:0] r;
		logic [POS_W-1:0] c;
		logic [RES_W-1:0] v;
		logic             eq;
		logic             is_last;
	} matrix_result_t;

	logic signed [ELEM_W-1:0] a_store [DEPTH];
	logic signed [ELEM_W-1:0] b_store [DEPTH];
	op_t                      op_now;
	logic [DIM_W-1:0]         dim_now;
	matrix_result_t           expected_results [$];
	matrix_result_t           head;
	longint                   wide_in;

	function automatic int span(input logic [DIM_W-1:0] d);
		if (d == '0)
			return 1;
		else if (d > DIM_W'(MAX_DIM))
			return MAX_DIM;
		else
			return int'(d);
	endfunction

	// Expand one compute request into its result items.
	task automatic predict_compute();
		int             n;
		longint         acc;
		logic           same;
		matrix_result_t item;
		n = span(dim_now);
		if (op_now == OP_EQ) begin
			same = 1'b1;
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					if (a_store[i*MAX_DIM+j] != b_store[i*MAX_DIM+j])
						same = 1'b0;
			item.r = '0;
			item.c = '0;
			item.v = '0;
			item.eq = same;
			item.is_last = 1'b1;
			expected_results.push_back(item);
		end else begin
			for (int i = 0; i < n; i++) begin
				for (int j = 0; j < n; j++) begin
					case (op_now)
						OP_ADD: acc = longint'(a_store[i*MAX_DIM+j]) + longint'(b_store[i*MAX_DIM+j]);
						OP_SUB: acc = longint'(a_store[i*MAX_DIM+j]) - longint'(b_store[i*MAX_DIM+j]);
						default: begin
							acc = 0;
							for (int k = 0; k < n; k++)
								acc += longint'(a_store[i*MAX_DIM+k]) * longint'(b_store[k*MAX_DIM+j]);
						end
					endcase
					item.r = POS_W'(i);
					item.c = POS_W'(j);
					item.v = acc[RES_W-1:0];
					item.eq = 1'b0;
					item.is_last = (i == n - 1) && (j == n - 1);
					expected_results.push_back(item);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			op_now = OP_ADD;
			dim_now = DIM_W'(MAX_DIM);
			errors = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_OPERATION: op_now = op_t'(pwdata[1:0]);
					REG_DIM:       dim_now = pwdata[DIM_W-1:0];
				endcase
			end
			if (in_valid && in_ready) begin
				wide_in = longint'(value);
				case (command)
					CMD_LOAD_A:  a_store[int'(row)*MAX_DIM + int'(col)] = wide_in[ELEM_W-1:0];
					CMD_LOAD_B:  b_store[int'(row)*MAX_DIM + int'(col)] = wide_in[ELEM_W-1:0];
					CMD_COMPUTE: predict_compute();
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: row_res %0d col_res %0d value_res %0d",
						row_res, col_res, value_res);
					errors++;
				end else begin
					head = expected_results.pop_front();
					checked++;
					if (row_res !== head.r) begin
						$error("row_res: expected %0d, got %0d", head.r, row_res);
						errors++;
					end
					if (col_res !== head.c) begin
						$error("col_res: expected %0d, got %0d", head.c, col_res);
						errors++;
					end
					if (value_res !== head.v) begin
						$error("value_res: expected %0d, got %0d", $signed(head.v), value_res);
						errors++;
					end
					if (equal !== head.eq) begin
						$error("equal: expected %0d, got %0d", head.eq, equal);
						errors++;
					end
					if (last !== head.is_last) begin
						$error("last: expected %0d, got %0d", head.is_last, last);
						errors++;
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== sim/square_matrix_arithmetic_core_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the matrix core: makes requests and register writes, gives the verdict.
module square_matrix_arithmetic_core_test;
	import sma_pkg::*;

	// Command code the core has no use for; it must be swallowed silently.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Idle time before a register write: covers the longest equality walk
	// plus loads still sitting in the request queue.
	localparam int SETTLE_CYCLES = 120;
	localparam int N_PHASES = 9;
	localparam int ITEMS_PER_PHASE = 5;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [1:0]              command = CMD_LOAD_A;
	logic [POS_W-1:0]        row = '0;
	logic [POS_W-1:0]        col = '0;
	logic signed [IN_W-1:0]  value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [POS_W-1:0]        row_res;
	logic [POS_W-1:0]        col_res;
	logic signed [RES_W-1:0] value_res;
	logic                    equal;
	logic                    last;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [2:0]              paddr = '0;
	logic [31:0]             pwdata = '0;
	logic [31:0]             prdata;
	logic                    pready;

	int errors;
	int pending_results;
	int checked;

	// Random idling on both channels; cleared for two phases of back-to-back traffic.
	logic gaps_on = 1'b1;

	// What the stimulus side remembers about the stores, so that a compute
	// never touches an element that was never loaded.
	bit                     written_a [DEPTH];
	bit                     written_b [DEPTH];
	logic signed [IN_W-1:0] shadow_a [DEPTH];
	logic signed [IN_W-1:0] shadow_b [DEPTH];
	op_t                    op_cfg = OP_ADD;
	logic [DIM_W-1:0]       dim_cfg = DIM_W'(MAX_DIM);

	int sent = 0;      // requests that do real work (loads and computes)
	int computes = 0;
	int settings = 0;

	op_t              phase_op  [N_PHASES] = '{OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_MUL,
		OP_ADD, OP_EQ, OP_SUB, OP_ADD};
	logic [DIM_W-1:0] phase_dim [N_PHASES] = '{4'd1, 4'd5, 4'd3, 4'd0, 4'd2,
		4'd5, 4'd4, 4'd3, 4'd4};

	square_matrix_arithmetic_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.row      (row),
		.col      (col),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row_res  (row_res),
		.col_res  (col_res),
		.value_res(value_res),
		.equal    (equal),
		.last     (last),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	square_matrix_arithmetic_checker result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.row      (row),
		.col      (col),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row_res  (row_res),
		.col_res  (col_res),
		.value_res(value_res),
		.equal    (equal),
		.last     (last),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.errors   (errors),
		.pending  (pending_results),
		.checked  (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side backpressure: one fresh draw per cycle, so a single
	// nonblocking write per time step.
	always @(posedge clk) begin
		out_ready <= gaps_on ? ($urandom_range(99) >= 16) : 1'b1;
	end

	// Rows and columns in use for a given dim setting (0 -> 1, clamp at max).
	function automatic int span(input logic [DIM_W-1:0] d);
		if (d == '0)
			return 1;
		else if (d > DIM_W'(MAX_DIM))
			return MAX_DIM;
		else
			return int'(d);
	endfunction

	// Element values lean on the extremes so the multiply hits full scale.
	function automatic logic signed [IN_W-1:0] pick_value();
		logic signed [IN_W-1:0] v;
		case ($urandom_range(7))
			0: v = {1'b1, {(IN_W-1){1'b0}}};
			1: v = {1'b0, {(IN_W-1){1'b1}}};
			2: v = '0;
			3: v = '1;
			default: v = IN_W'($urandom);
		endcase
		return v;
	endfunction

	// Push one request. Valid only drops when an idle gap is actually taken,
	// so back-to-back requests keep valid high with one assignment per step.
	task automatic send_req(input logic [1:0] cmd, input logic [POS_W-1:0] r,
			input logic [POS_W-1:0] c, input logic signed [IN_W-1:0] v);
		while (gaps_on && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		row <= r;
		col <= c;
		value <= v;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_LOAD_A) begin
			written_a[int'(r)*MAX_DIM + int'(c)] = 1'b1;
			shadow_a[int'(r)*MAX_DIM + int'(c)] = v;
		end else if (cmd == CMD_LOAD_B) begin
			written_b[int'(r)*MAX_DIM + int'(c)] = 1'b1;
			shadow_b[int'(r)*MAX_DIM + int'(c)] = v;
		end
		if (cmd != CMD_UNUSED)
			sent++;
	endtask

	// Drain: stop requesting, wait for every predicted result, then give
	// the queue time to swallow trailing loads that produce nothing.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup phase, access phase, then psel drops before the task returns, so psel
	// never gets two assignments in one step across consecutive writes.
	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == REG_OPERATION)
			op_cfg = op_t'(data[1:0]);
		else
			dim_cfg = data[DIM_W-1:0];
	endtask

	task automatic configure(input op_t op, input logic [DIM_W-1:0] d);
		apb_write(REG_OPERATION, 32'(op));
		apb_write(REG_DIM, 32'(d));
		settings++;
	endtask

	// Copy A into B over the active square, so equality can come out true.
	task automatic mirror_a_into_b();
		int n;
		n = span(dim_cfg);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (!written_b[i*MAX_DIM+j] || shadow_b[i*MAX_DIM+j] !== shadow_a[i*MAX_DIM+j])
					send_req(CMD_LOAD_B, POS_W'(i), POS_W'(j), shadow_a[i*MAX_DIM+j]);
	endtask

	// Compute request, preceded by loads for any element of the active
	// square that has never been written.
	task automatic issue_compute();
		int n;
		n = span(dim_cfg);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				if (!written_a[i*MAX_DIM+j])
					send_req(CMD_LOAD_A, POS_W'(i), POS_W'(j), pick_value());
				if (!written_b[i*MAX_DIM+j])
					send_req(CMD_LOAD_B, POS_W'(i), POS_W'(j), pick_value());
			end
		if (op_cfg == OP_EQ && $urandom_range(1) == 1)
			mirror_a_into_b();
		send_req(CMD_COMPUTE, POS_W'($urandom), POS_W'($urandom), IN_W'($urandom));
		computes++;
	endtask

	initial begin
		int          goal;
		int          roll;
		int          n;
		logic [1:0]  which;
		logic [POS_W-1:0] r;
		logic [POS_W-1:0] c;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// Directed: 2x2 matrices built from the value extremes, every
		// operation over the same data, then equality both ways.
		configure(OP_ADD, 4'd2);
		send_req(CMD_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
		send_req(CMD_LOAD_A, 3'd0, 3'd1, 16'sh8000);
		send_req(CMD_LOAD_A, 3'd1, 3'd0, -16'sd1);
		send_req(CMD_LOAD_A, 3'd1, 3'd1, 16'sd0);
		send_req(CMD_LOAD_B, 3'd0, 3'd0, 16'sh7fff);
		send_req(CMD_LOAD_B, 3'd0, 3'd1, 16'sh8000);
		send_req(CMD_LOAD_B, 3'd1, 3'd0, 16'sd1);
		send_req(CMD_LOAD_B, 3'd1, 3'd1, 16'sh8000);
		issue_compute();
		settle();
		configure(OP_SUB, 4'd2);
		issue_compute();
		settle();
		configure(OP_MUL, 4'd2);
		issue_compute();
		settle();
		// unequal first, then with A copied into B
		configure(OP_EQ, 4'd2);
		send_req(CMD_COMPUTE, 3'd7, 3'd7, 16'sh7fff);
		computes++;
		// unknown command, and loads in the last row outside the square
		send_req(CMD_UNUSED, 3'd7, 3'd7, 16'sh8000);
		send_req(CMD_LOAD_A, 3'd7, 3'd7, 16'sh5a5a);
		send_req(CMD_LOAD_B, 3'd7, 3'd0, -16'sh5a5b);
		mirror_a_into_b();
		send_req(CMD_COMPUTE, 3'd0, 3'd0, 16'sd0);
		computes++;

		// Random phases, one register setting each; the last setting is drawn.
		phase_op[N_PHASES-1] = op_t'($urandom_range(3));
		phase_dim[N_PHASES-1] = DIM_W'($urandom_range(5));
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			configure(phase_op[p], phase_dim[p]);
			// two middle phases run with no idling on either side
			gaps_on = (p != 4 && p != 5);
			n = span(dim_cfg);
			goal = sent + ITEMS_PER_PHASE;
			while (sent < goal) begin
				roll = $urandom_range(99);
				if (roll < 8) begin
					send_req(CMD_UNUSED, POS_W'($urandom), POS_W'($urandom), IN_W'($urandom));
				end else if (roll < 22) begin
					issue_compute();
				end else begin
					which = ($urandom_range(1) == 1) ? CMD_LOAD_B : CMD_LOAD_A;
					if ($urandom_range(3) != 0) begin
						r = POS_W'($urandom_range(n - 1));
						c = POS_W'($urandom_range(n - 1));
					end else begin
						r = POS_W'($urandom_range(MAX_DIM - 1));
						c = POS_W'($urandom_range(MAX_DIM - 1));
					end
					send_req(which, r, c, pick_value());
				end
			end
			issue_compute();
		end
		gaps_on = 1'b1;
		settle();

		$display("Covered %0d load/compute requests (%0d computes) over %0d register settings,",
			sent, computes, settings);
		$display("dims 0 to 5 and all four operations; %0d result items compared.", checked);
		if (errors == 0 && pending_results == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (all 8x8 multiplies under
	// full backpressure).
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
